// ===== hdl/via_pkg.sv =====
// Shared types and constants for the versatile interface adapter.
package via_pkg;

	localparam int InW  = 40;
	localparam int OutW = 40;

	typedef enum logic [1:0] {
		MODE_TICK  = 2'd0,
		MODE_READ  = 2'd1,
		MODE_WRITE = 2'd2,
		MODE_NONE  = 2'd3
	} mode_t;

	localparam logic [3:0] REG_ORB  = 4'h0;
	localparam logic [3:0] REG_ORA  = 4'h1;
	localparam logic [3:0] REG_DDRB = 4'h2;
	localparam logic [3:0] REG_DDRA = 4'h3;
	localparam logic [3:0] REG_T1CL = 4'h4;
	localparam logic [3:0] REG_T1CH = 4'h5;
	localparam logic [3:0] REG_T1LL = 4'h6;
	localparam logic [3:0] REG_T1LH = 4'h7;
	localparam logic [3:0] REG_T2CL = 4'h8;
	localparam logic [3:0] REG_T2CH = 4'h9;
	localparam logic [3:0] REG_SR   = 4'ha;
	localparam logic [3:0] REG_ACR  = 4'hb;
	localparam logic [3:0] REG_PCR  = 4'hc;
	localparam logic [3:0] REG_IFR  = 4'hd;
	localparam logic [3:0] REG_IER  = 4'he;

	localparam logic [7:0] F_CA2 = 8'h01;
	localparam logic [7:0] F_CA1 = 8'h02;
	localparam logic [7:0] F_SR  = 8'h04;
	localparam logic [7:0] F_CB2 = 8'h08;
	localparam logic [7:0] F_CB1 = 8'h10;
	localparam logic [7:0] F_T2  = 8'h20;
	localparam logic [7:0] F_T1  = 8'h40;

	typedef struct packed {
		logic [7:0] read_data;
		logic       irq_out;
		logic [7:0] port_a_drive;
		logic [7:0] port_b_drive;
		logic       pb7_level;
		logic       ca2_level;
		logic       cb1_level;
		logic       cb2_level;
	} via_out_t;

	// Apply an interrupt flag change and refresh the summary bit.
	function automatic logic [7:0] irq_fix(input logic [7:0] f, input logic [6:0] ier);
		logic [7:0] r;
		r = f;
		r[7] = |(ier & f[6:0]);
		return r;
	endfunction

endpackage

// ===== hdl/via_core.sv =====
// Register file, timers, shift register and handshake logic of the adapter.
module via_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [1:0]          mode,
	input  logic [3:0]          reg_offset,
	input  logic [7:0]          write_data,
	input  logic [7:0]          port_a_pins,
	input  logic [7:0]          port_b_pins,
	input  logic                cb2_pin,
	output via_pkg::via_out_t   result
);
	import via_pkg::*;

	logic [7:0] ora_q, orb_q, ddra_q, ddrb_q, ila_q, ilb_q, acr_q, pcr_q, ifr_q;
	logic [6:0] ier_q;
	logic [15:0] t1l_q, t2l_q;
	logic [16:0] t1c_q, t2c_q;
	logic t1jl_q, t2jl_q, t1arm_q, t2arm_q;
	logic [7:0] sr_q;
	logic sact_q, sph_q;
	logic [2:0] sbits_q;
	logic [1:0] ca2h_q;
	logic ca2_q, cb1_q, cb2_q, pb6p_q, pb7_q;

	logic [7:0] ora, orb, ddra, ddrb, ila, ilb, acr, pcr, ifr;
	logic [6:0] ier;
	logic [15:0] t1l, t2l;
	logic [16:0] t1c, t2c;
	logic t1jl, t2jl, t1arm, t2arm;
	logic [7:0] sr;
	logic sact, sph;
	logic [2:0] sbits;
	logic [1:0] ca2h;
	logic ca2, cb1, cb2, pb6p, pb7;
	logic [7:0] rd, pbl;
	logic pb6, neg, sin, sout;
	logic [4:0] sm;

	// Compute the next state for one bus cycle.
	always_comb begin
		ora = ora_q; orb = orb_q; ddra = ddra_q; ddrb = ddrb_q;
		ila = ila_q; ilb = ilb_q; acr = acr_q; pcr = pcr_q; ifr = ifr_q;
		ier = ier_q; t1l = t1l_q; t2l = t2l_q; t1c = t1c_q; t2c = t2c_q;
		t1jl = t1jl_q; t2jl = t2jl_q; t1arm = t1arm_q; t2arm = t2arm_q;
		sr = sr_q; sact = sact_q; sph = sph_q; sbits = sbits_q; ca2h = ca2h_q;
		ca2 = ca2_q; cb1 = cb1_q; cb2 = cb2_q; pb6p = pb6p_q; pb7 = pb7_q;
		rd = 8'h00; pb6 = 1'b0; neg = 1'b0; sin = 1'b0; sout = 1'b0; sm = 5'd0;
		pbl = (port_b_pins & ~ddrb_q) | (orb_q & ddrb_q);

		if (!acr[0]) ila = port_a_pins;
		if (!acr[1]) ilb = port_b_pins;

		// Register access.
		if (mode == MODE_READ) begin
			case (reg_offset)
				REG_ORB: begin
					rd = acr[1] ? ilb : pbl;
					if (acr[7]) rd[7] = pb7;
					ifr = irq_fix(ifr & ~(F_CB1 | (((pcr & 8'ha0) == 8'h20) ? 8'h00 : F_CB2)), ier);
				end
				REG_ORA: begin
					rd = acr[0] ? ila : ((port_a_pins & ~ddra) | (ora & ddra));
					ifr = irq_fix(ifr & ~(F_CA1 | (((pcr & 8'h0a) == 8'h02) ? 8'h00 : F_CA2)), ier);
					if ((pcr & 8'h0e) == 8'h08 || (pcr & 8'h0e) == 8'h0a) begin
						ca2 = 1'b0;
						if ((pcr & 8'h0e) == 8'h0a) ca2h = 2'd1;
					end
				end
				REG_DDRB: rd = ddrb;
				REG_DDRA: rd = ddra;
				REG_T1CL: begin ifr = irq_fix(ifr & ~F_T1, ier); rd = t1c[7:0]; end
				REG_T1CH: rd = t1c[15:8];
				REG_T1LL: rd = t1l[7:0];
				REG_T1LH: rd = t1l[15:8];
				REG_T2CL: begin ifr = irq_fix(ifr & ~F_T2, ier); rd = t2c[7:0]; end
				REG_T2CH: rd = t2c[15:8];
				REG_SR: begin
					ifr = irq_fix(ifr & ~F_SR, ier);
					if (acr[4:2] != 3'd0) begin sph = 1'b0; sbits = 3'd0; sact = 1'b1; end
					rd = sr;
				end
				REG_ACR: rd = acr;
				REG_PCR: rd = pcr;
				REG_IFR: rd = ifr;
				REG_IER: rd = {1'b1, ier};
				default: rd = acr[0] ? ila : ((port_a_pins & ~ddra) | (ora & ddra));
			endcase
		end else if (mode == MODE_WRITE) begin
			case (reg_offset)
				REG_ORB: begin
					orb = write_data;
					ifr = irq_fix(ifr & ~(F_CB1 | (((pcr & 8'ha0) == 8'h20) ? 8'h00 : F_CB2)), ier);
					if (pcr[7:6] == 2'b10) cb2 = 1'b0;
				end
				REG_ORA: begin
					ora = write_data;
					ifr = irq_fix(ifr & ~(F_CA1 | (((pcr & 8'h0a) == 8'h02) ? 8'h00 : F_CA2)), ier);
					if ((pcr & 8'h0e) == 8'h08 || (pcr & 8'h0e) == 8'h0a) begin
						ca2 = 1'b0;
						if ((pcr & 8'h0e) == 8'h0a) ca2h = 2'd1;
					end
				end
				REG_DDRB: ddrb = write_data;
				REG_DDRA: ddra = write_data;
				REG_T1CL, REG_T1LL: t1l[7:0] = write_data;
				REG_T1CH: begin
					t1l[15:8] = write_data;
					t1c = {1'b0, t1l};
					t1jl = 1'b1; t1arm = 1'b1; pb7 = 1'b0;
					ifr = irq_fix(ifr & ~F_T1, ier);
				end
				REG_T1LH: begin t1l[15:8] = write_data; ifr = irq_fix(ifr & ~F_T1, ier); end
				REG_T2CL: t2l[7:0] = write_data;
				REG_T2CH: begin
					t2l[15:8] = write_data;
					t2c = {1'b0, t2l};
					t2jl = 1'b1; t2arm = 1'b1;
					ifr = irq_fix(ifr & ~F_T2, ier);
				end
				REG_SR: begin
					ifr = irq_fix(ifr & ~F_SR, ier);
					if (acr[4:2] != 3'd0) begin sph = 1'b0; sbits = 3'd0; sact = 1'b1; end
					sr = write_data;
				end
				REG_ACR: begin
					acr = write_data;
					if (write_data[4:2] == 3'd0) begin
						sact = 1'b0;
						ifr = irq_fix(ifr & ~F_SR, ier);
					end
				end
				REG_PCR: begin
					pcr = write_data;
					if (write_data[3:1] == 3'b110) begin ca2 = 1'b0; ca2h = 2'b11; end
					if (write_data[3:1] == 3'b111) begin ca2 = 1'b1; ca2h = 2'b11; end
				end
				REG_IFR: ifr = irq_fix(ifr & ~{1'b0, write_data[6:0]}, ier);
				REG_IER: begin
					if (write_data[7]) ier = ier | write_data[6:0];
					else ier = ier & ~write_data[6:0];
					ifr = irq_fix(ifr, ier);
				end
				default: ora = write_data;
			endcase
		end

		// Clock tick: CA2 pulse.
		if (!ca2h[1]) begin
			ca2h = ca2h - 2'd1;
			if (ca2h[1]) ca2 = 1'b1;
		end

		// Timer 1.
		if (t1jl) t1jl = 1'b0;
		else if (!t1c[16]) t1c = t1c - 17'd1;
		else begin
			if (t1arm) begin
				ifr = irq_fix(ifr | F_T1, ier);
				case (acr[7:6])
					2'b00: t1arm = 1'b0;
					2'b10: begin t1arm = 1'b0; pb7 = 1'b1; end
					2'b11: pb7 = ~pb7;
					default: ;
				endcase
			end
			t1c = {1'b0, t1l};
		end

		// Timer 2 and its shift clocking.
		pb6 = ((port_b_pins[6] & ~ddrb[6]) | (orb[6] & ddrb[6]));
		neg = pb6p & ~pb6;
		pb6p = pb6;
		sm = acr[4:0] & 5'h1c;
		if (!t2c[16]) begin
			if (t2jl) t2jl = 1'b0;
			else if (!acr[5] || neg) t2c = t2c - 17'd1;
		end else begin
			if (t2arm) begin ifr = irq_fix(ifr | F_T2, ier); t2arm = 1'b0; end
			sin = (sm == 5'h04);
			sout = (sm == 5'h10) || (sm == 5'h14);
			t2c = {1'b0, t2l};
		end
		if (sm == 5'h08) sin = 1'b1;
		if (sm == 5'h18) sout = 1'b1;

		// One shift step: at most one fires per cycle.
		if ((sin || sout) && sact) begin
			if (sph) begin
				cb1 = 1'b1;
				if (sin) sr = {sr[6:0], cb2_pin};
				else begin cb2 = sr[7]; sr = {sr[6:0], sr[7]}; end
				if (sin || sm != 5'h10) begin
					sbits = sbits + 3'd1;
					if (sbits == 3'd0) begin
						ifr = irq_fix(ifr | F_SR, ier);
						sact = 1'b0;
					end
				end
			end else cb1 = 1'b0;
			sph = ~sph;
		end
	end

	// Hold control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ora_q <= '0; orb_q <= '0; ddra_q <= '0; ddrb_q <= '0; ila_q <= '0;
			ilb_q <= '0; acr_q <= '0; pcr_q <= '0; ifr_q <= '0; ier_q <= '0;
			t1l_q <= '0; t2l_q <= '0; t1c_q <= '0; t2c_q <= '0;
			t1jl_q <= 1'b0; t2jl_q <= 1'b0; t1arm_q <= 1'b0; t2arm_q <= 1'b0;
			sr_q <= '0; sact_q <= 1'b0; sph_q <= 1'b0; sbits_q <= '0;
			ca2h_q <= 2'b11; ca2_q <= 1'b0; cb1_q <= 1'b0; cb2_q <= 1'b0;
			pb6p_q <= 1'b0; pb7_q <= 1'b0;
		end else if (step) begin
			ora_q <= ora; orb_q <= orb; ddra_q <= ddra; ddrb_q <= ddrb; ila_q <= ila;
			ilb_q <= ilb; acr_q <= acr; pcr_q <= pcr; ifr_q <= ifr; ier_q <= ier;
			t1l_q <= t1l; t2l_q <= t2l; t1c_q <= t1c; t2c_q <= t2c;
			t1jl_q <= t1jl; t2jl_q <= t2jl; t1arm_q <= t1arm; t2arm_q <= t2arm;
			sr_q <= sr; sact_q <= sact; sph_q <= sph; sbits_q <= sbits;
			ca2h_q <= ca2h; ca2_q <= ca2; cb1_q <= cb1; cb2_q <= cb2;
			pb6p_q <= pb6p; pb7_q <= pb7;
		end
	end

	// Form the result of this cycle.
	always_comb begin
		result.read_data    = rd;
		result.irq_out      = ifr[7];
		result.port_a_drive = ora & ddra;
		result.port_b_drive = orb & ddrb;
		result.pb7_level    = pb7;
		result.ca2_level    = ca2;
		result.cb1_level    = cb1;
		result.cb2_level    = cb2;
	end

endmodule

// ===== hdl/versatile_interface_adapter.sv =====
// Top level of the versatile interface adapter with stream ports.
//
// One transaction on the s_axis side is one bus cycle: a plain tick, a
// register read or a register write, followed by that cycle's clock tick.
// Each accepted transaction yields exactly one m_axis transaction carrying
// read data, the IRQ line and the port and handshake output levels.
// The input is registered in an input stage (_s1); the state update and the
// result are computed from that stage into the output register. Throughput
// is one transaction per cycle while m_axis does not stall.
// The state advances only when the input stage moves into the result
// register, so a stall on m_axis holds all state; s_axis_tready stays high
// while the input stage is empty or moving on.
// Reset clears all state, with the CA2 pulse counter idle, and empties both
// stages.
module versatile_interface_adapter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// mode[1:0], reg_offset[5:2], write_data[13:6], port_a_pins[21:14],
	// port_b_pins[29:22], cb2_pin[30], zero fill [39:31]
	input  logic [39:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// read_data[7:0], irq_out[8], port_a_drive[16:9], port_b_drive[24:17],
	// pb7_level[25], ca2_level[26], cb1_level[27], cb2_level[28], zero fill [39:29]
	output logic [39:0] m_axis_tdata
);
	import via_pkg::*;

	logic        vld_s1;
	logic [30:0] dat_s1;
	logic        out_vld_q;
	logic [28:0] out_q;
	logic        step;
	via_out_t    res;

	assign step          = vld_s1 && (!out_vld_q || m_axis_tready);
	assign s_axis_tready = !vld_s1 || step;

	via_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.mode        (dat_s1[1:0]),
		.reg_offset  (dat_s1[5:2]),
		.write_data  (dat_s1[13:6]),
		.port_a_pins (dat_s1[21:14]),
		.port_b_pins (dat_s1[29:22]),
		.cb2_pin     (dat_s1[30]),
		.result      (res)
	);

	// Advance the input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			dat_s1 <= s_axis_tdata[30:0];
		end
	end

	// Hold the result until taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (step) begin
			out_vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_q <= {res.cb2_level, res.cb1_level, res.ca2_level, res.pb7_level,
				res.port_b_drive, res.port_a_drive, res.irq_out, res.read_data};
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {11'd0, out_q};

endmodule

// ===== hdl/via_checker.sv =====
// Port checker for the versatile interface adapter, bound to the top level.
module via_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [39:0] m_axis_tdata
);
	// Hold a stalled result.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed");

	// Keep the fill bits zero.
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[39:29] == 11'd0)
		else $error("fill bits set");

	// Accept input whenever the output side is free.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tready |-> s_axis_tready)
		else $error("input stalled with free output");

	// A result follows every accepted transaction.
	a_follow: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> ##1 m_axis_tvalid)
		else $error("accepted transaction lost");

endmodule

bind versatile_interface_adapter via_checker u_via_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
